// File: rtl/bsot_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsot_pkg
// Shared types and constants for the beat sync and onset tracker.
// ----------------------------------------------------------------------------
package bsot_pkg;

  localparam logic [1:0] REG_CAL_LOW  = 2'd0;
  localparam logic [1:0] REG_CAL_HIGH = 2'd1;
  localparam logic [1:0] REG_HYST     = 2'd2;
  localparam logic [1:0] REG_DECAY    = 2'd3;

  localparam logic [7:0] HALF_LEVEL   = 8'd128;
  localparam logic [7:0] RANGE_LOW_INIT  = 8'd255;
  localparam logic [7:0] RANGE_HIGH_INIT = 8'd50;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_LOG,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_OUT
  } state_t;

endpackage

// File: rtl/beat_sync_and_onset_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beat_sync_and_onset_tracker
// Beat sync averaging, calibrated volume follower, onset detection and
// history range tracking.
// ----------------------------------------------------------------------------
// After acceptance an item waits for the calibration divider when its volume
// slot needs it, then passes the log step, then the min/max walk, which reads
// the history RAM one entry a cycle. After reset the history RAM is cleared,
// during which no item is accepted. The result is held in an output register
// until taken; the next item is accepted the cycle after it is taken.
module beat_sync_and_onset_tracker #(
  parameter int SYNC_TAPS     = 4,
  parameter int VOLUME_TAPS   = 8,
  parameter int HISTORY_DEPTH = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [9:0] sync_raw,
  input  logic [9:0] volume_raw,
  input  logic       sync_slot,
  input  logic       volume_slot,
  input  logic       dynamic_slot,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] sync_level,
  output logic       beat_tick,
  output logic       half_tick,
  output logic [4:0] beat_phase,
  output logic [7:0] volume_level,
  output logic [7:0] envelope,
  output logic       onset_flag,
  output logic [7:0] onset_strength,
  output logic [7:0] range_low,
  output logic [7:0] range_high
);

  localparam int SW = (SYNC_TAPS > 1) ? $clog2(SYNC_TAPS) : 1;
  localparam int VW = (VOLUME_TAPS > 1) ? $clog2(VOLUME_TAPS) : 1;
  localparam int HW = $clog2(HISTORY_DEPTH);
  localparam int SSW = 8 + $clog2(SYNC_TAPS + 1);
  localparam int VSW = 8 + $clog2(VOLUME_TAPS + 1);

  bsot_pkg::state_t state, state_next;

  logic [9:0] cal_low, cal_high;
  logic [7:0] hyst, decay;

  logic [7:0]  sync_taps [SYNC_TAPS];
  logic [SW-1:0] sync_pos;
  logic [7:0]  prev_sync, prev_half;
  logic [4:0]  phase;
  logic [7:0]  volume_taps [VOLUME_TAPS];
  logic [VW-1:0] volume_pos;
  logic [HW-1:0] hist_pos;
  logic [7:0]  env_level, prev_vol, held_str;
  logic        held_onset;

  logic [9:0]  vraw_q;
  logic        vslot_q, dslot_q;
  logic [7:0]  vmap;
  logic [HW-1:0] scan_addr, clr_addr;
  logic [7:0]  lo_acc, hi_acc;
  logic        hist0_hit;
  logic [7:0]  hist0_val;
  logic [7:0]  scan_data;

  logic        div_start, div_busy;
  logic [17:0] div_dividend, div_q;
  logic [9:0]  clamped;

  logic        ram_we;
  logic [HW-1:0] ram_waddr, ram_raddr;
  logic [7:0]  ram_wdata, ram_rdata;

  logic        accept;
  logic [7:0]  sync_s;
  logic        clear_fall;
  logic [SSW-1:0] ssum;
  logic [7:0]  level;
  logic [VSW-1:0] vsum;
  logic [7:0]  vol;
  logic [8:0]  thresh;
  logic [8:0]  rise2;

  assign accept = in_valid && in_ready;
  assign sync_s = sync_raw[9:2];

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      cal_low  <= '0;
      cal_high <= 10'd1023;
      hyst     <= '0;
      decay    <= 8'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        bsot_pkg::REG_CAL_LOW:  cal_low  <= cfg_data;
        bsot_pkg::REG_CAL_HIGH: cal_high <= cfg_data;
        bsot_pkg::REG_HYST:     hyst     <= cfg_data[7:0];
        bsot_pkg::REG_DECAY:    decay    <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // sync path, evaluated at acceptance
  always_comb begin
    ssum = '0;
    for (int i = 0; i < SYNC_TAPS; i++) begin
      if (sync_slot && sync_pos == SW'(i)) begin
        ssum = ssum + SSW'(sync_s);
      end else begin
        ssum = ssum + SSW'(sync_taps[i]);
      end
    end
    clear_fall = (prev_sync > bsot_pkg::HALF_LEVEL) &&
                 (sync_s < prev_sync - bsot_pkg::HALF_LEVEL);
    level = clear_fall ? 8'd0 : 8'(ssum / SYNC_TAPS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SYNC_TAPS; i++) sync_taps[i] <= '0;
      sync_pos  <= '0;
      prev_sync <= '0;
      prev_half <= '0;
      phase     <= '0;
    end else if (accept) begin
      for (int i = 0; i < SYNC_TAPS; i++) begin
        if (clear_fall) begin
          sync_taps[i] <= '0;
        end else if (sync_slot && sync_pos == SW'(i)) begin
          sync_taps[i] <= sync_s;
        end
      end
      if (sync_slot) begin
        sync_pos <= (sync_pos == SW'(SYNC_TAPS - 1)) ? '0 : sync_pos + SW'(1);
      end
      if (prev_sync > bsot_pkg::HALF_LEVEL && level < prev_sync - bsot_pkg::HALF_LEVEL) begin
        phase <= phase + 5'd1;
      end
      prev_sync <= level;
      prev_half <= level;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sync_level <= level;
      beat_tick  <= (prev_sync > bsot_pkg::HALF_LEVEL) &&
                    (level < prev_sync - bsot_pkg::HALF_LEVEL);
      half_tick  <= (level > bsot_pkg::HALF_LEVEL) && (prev_half <= bsot_pkg::HALF_LEVEL);
      vraw_q  <= volume_raw;
      vslot_q <= volume_slot;
      dslot_q <= dynamic_slot;
    end
  end

  // volume mapping through the divider, started at acceptance when cal_high > cal_low
  always_comb begin
    clamped = volume_raw;
    if (clamped < cal_low) clamped = cal_low;
    if (clamped > cal_high) clamped = cal_high;
    div_dividend = 18'({8'd0, clamped - cal_low} * 18'd255);
  end

  assign div_start = (state == bsot_pkg::ST_IDLE) && accept && volume_slot &&
                     (cal_high > cal_low);

  bsot_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (cal_high - cal_low),
    .busy     (div_busy),
    .quotient (div_q)
  );

  always_comb begin
    if (cal_high <= cal_low) begin
      vmap = (vraw_q > cal_low) ? 8'd255 : 8'd0;
    end else begin
      vmap = div_q[7:0];
    end
  end

  always_comb begin
    vsum = '0;
    for (int i = 0; i < VOLUME_TAPS; i++) begin
      if (vslot_q && volume_pos == VW'(i)) begin
        vsum = vsum + VSW'(vmap);
      end else begin
        vsum = vsum + VSW'(volume_taps[i]);
      end
    end
    vol    = 8'(vsum / VOLUME_TAPS);
    thresh = {1'b0, prev_vol} + {1'b0, hyst};
    rise2  = {vol - prev_vol, 1'b0};
  end

  // state machine
  always_comb begin
    state_next = state;
    case (state)
      bsot_pkg::ST_CLEAR:
        if (clr_addr == HW'(HISTORY_DEPTH - 1)) state_next = bsot_pkg::ST_IDLE;
      bsot_pkg::ST_IDLE:
        if (accept) state_next = bsot_pkg::ST_DIV;
      bsot_pkg::ST_DIV:
        if (!div_busy) state_next = bsot_pkg::ST_LOG;
      bsot_pkg::ST_LOG:
        state_next = bsot_pkg::ST_SCAN;
      bsot_pkg::ST_SCAN:
        if (scan_addr == HW'(HISTORY_DEPTH - 1)) state_next = bsot_pkg::ST_SCAN_LAST;
      bsot_pkg::ST_SCAN_LAST:
        state_next = bsot_pkg::ST_OUT;
      bsot_pkg::ST_OUT:
        if (out_ready) state_next = bsot_pkg::ST_IDLE;
      default:
        state_next = bsot_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == bsot_pkg::ST_IDLE);
    out_valid = (state == bsot_pkg::ST_OUT);
    ram_we    = 1'b0;
    ram_waddr = hist_pos;
    ram_wdata = env_level;
    ram_raddr = scan_addr;
    case (state)
      bsot_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = '0;
      end
      bsot_pkg::ST_LOG: begin
        ram_we = dslot_q;
      end
      default: ;
    endcase
  end

  bsot_ram #(.WIDTH(8), .DEPTH(HISTORY_DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= bsot_pkg::ST_CLEAR;
      clr_addr   <= '0;
      scan_addr  <= '0;
      for (int i = 0; i < VOLUME_TAPS; i++) volume_taps[i] <= '0;
      volume_pos <= '0;
      hist_pos   <= '0;
      env_level  <= '0;
      prev_vol   <= '0;
      held_onset <= 1'b0;
      held_str   <= '0;
    end else begin
      state <= state_next;
      if (state == bsot_pkg::ST_CLEAR) clr_addr <= clr_addr + HW'(1);
      if (state == bsot_pkg::ST_LOG) begin
        scan_addr <= HW'(1);
        if (vslot_q) begin
          volume_taps[volume_pos] <= vmap;
          volume_pos <= (volume_pos == VW'(VOLUME_TAPS - 1)) ? '0 : volume_pos + VW'(1);
        end
        if (dslot_q) begin
          hist_pos <= (hist_pos == HW'(HISTORY_DEPTH - 1)) ? '0 : hist_pos + HW'(1);
          if ({1'b0, vol} > thresh && vol > env_level) begin
            held_onset <= 1'b1;
            env_level  <= vol;
            held_str   <= rise2[8] ? 8'd255 : rise2[7:0];
          end else begin
            held_onset <= 1'b0;
            env_level  <= (env_level >= decay) ? env_level - decay : 8'd0;
          end
          prev_vol <= vol;
        end
      end else if (state == bsot_pkg::ST_SCAN) begin
        scan_addr <= scan_addr + HW'(1);
      end else if (state == bsot_pkg::ST_DIV) begin
        scan_addr <= '0;
      end
    end
  end

  // entry 0 is read in ST_LOG alongside the log write; forward the new value
  assign scan_data = (state == bsot_pkg::ST_SCAN && scan_addr == HW'(1) && hist0_hit) ?
                     hist0_val : ram_rdata;

  // min/max walk; in ST_LOG the read of entry 0 is issued, data follows
  always_ff @(posedge clk) begin
    if (state == bsot_pkg::ST_LOG) begin
      lo_acc       <= bsot_pkg::RANGE_LOW_INIT;
      hi_acc       <= bsot_pkg::RANGE_HIGH_INIT;
      volume_level <= vol;
      hist0_hit    <= dslot_q && (hist_pos == '0);
      hist0_val    <= env_level;
    end else if (state == bsot_pkg::ST_SCAN || state == bsot_pkg::ST_SCAN_LAST) begin
      if (scan_data < lo_acc) lo_acc <= scan_data;
      if (scan_data > hi_acc) hi_acc <= scan_data;
    end
  end

  assign range_low      = lo_acc;
  assign range_high     = hi_acc;
  assign beat_phase     = phase;
  assign envelope       = env_level;
  assign onset_flag     = held_onset;
  assign onset_strength = held_str;

  a_ready_excl: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input and output open together");
  a_high_floor: assert property (@(posedge clk) disable iff (rst)
    (state == bsot_pkg::ST_OUT) |-> (range_high >= bsot_pkg::RANGE_HIGH_INIT))
    else $error("range high below start value");
  a_range_order: assert property (@(posedge clk) disable iff (rst)
    (state == bsot_pkg::ST_OUT) |-> (range_low <= range_high))
    else $error("range order");
  a_no_walk_write: assert property (@(posedge clk) disable iff (rst)
    (state == bsot_pkg::ST_SCAN) |-> !ram_we)
    else $error("write during walk");

endmodule

// File: rtl/bsot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsot_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module bsot_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/bsot_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsot_divider
// Restoring divider, one quotient bit per cycle, for the volume mapping.
// ----------------------------------------------------------------------------
module bsot_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [17:0] dividend,
  input  logic [9:0]  divisor,
  output logic        busy,
  output logic [17:0] quotient
);

  logic [4:0]  count;
  logic [10:0] rem;
  logic [10:0] rem_shift;
  logic [9:0]  dsr;

  assign rem_shift = {rem[9:0], quotient[17]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy     <= 1'b1;
      count    <= 5'd18;
      rem      <= '0;
      quotient <= dividend;
      dsr      <= divisor;
    end else if (busy) begin
      if (rem_shift >= {1'b0, dsr}) begin
        rem <= rem_shift - {1'b0, dsr};
        quotient <= {quotient[16:0], 1'b1};
      end else begin
        rem <= rem_shift;
        quotient <= {quotient[16:0], 1'b0};
      end
      count <= count - 5'd1;
      if (count == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  a_busy_count: assert property (@(posedge clk) disable iff (rst) busy |-> (count != 5'd0))
    else $error("divider busy with zero count");

endmodule
